/* sv/segint_pkg.sv */
// Shared types and constants for the segment intersection test.
// Verdict codes carried on the result channel. No dependencies.
package segint_pkg;

  localparam int VERDICT_W = 2;

  typedef enum logic [VERDICT_W-1:0] {
    VERDICT_NONE    = 2'd0,
    VERDICT_POINT   = 2'd1,
    VERDICT_OVERLAP = 2'd2
  } verdict_t;

endpackage

/* sv/segment_intersection_test.sv */
// Segment intersection test: four-register pipeline, one segment pair per beat.
// Depends on segint_pkg (verdict codes).
//
//  channel | ports                          | direction | handshake
//  in      | in_a_*/in_b_* (8 coords)       | input     | in_valid / in_ready
//  out     | out_verdict                    | output    | out_valid / out_ready
//
// Throughput: one pair per cycle while out is not stalled; a beat passes the four registers below in order.
// Stages: input register, six products, three cross products, verdict register.
// The longest path is one (COORD_WIDTH+1)-bit signed multiply per stage.
// Synchronous active-low reset clears the stage valid bits only.
// A stalled result freezes every stage; in_ready drops only while out is stalled.
module segment_intersection_test #(
  parameter int COORD_WIDTH = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [COORD_WIDTH-1:0] in_a_start_x,
  input  logic signed [COORD_WIDTH-1:0] in_a_start_y,
  input  logic signed [COORD_WIDTH-1:0] in_a_end_x,
  input  logic signed [COORD_WIDTH-1:0] in_a_end_y,
  input  logic signed [COORD_WIDTH-1:0] in_b_start_x,
  input  logic signed [COORD_WIDTH-1:0] in_b_start_y,
  input  logic signed [COORD_WIDTH-1:0] in_b_end_x,
  input  logic signed [COORD_WIDTH-1:0] in_b_end_y,
  output logic                          out_valid,
  input  logic                          out_ready,
  output segint_pkg::verdict_t          out_verdict
);

  localparam int DW = COORD_WIDTH + 1;  // differences
  localparam int PW = 2 * DW;           // products
  localparam int CW = PW + 1;           // cross products

  logic en;
  logic v1_r, v2_r, v3_r, out_valid_r;

  // stage 1: input register
  logic signed [COORD_WIDTH-1:0] ax0_r, ay0_r, ax1_r, ay1_r;
  logic signed [COORD_WIDTH-1:0] bx0_r, by0_r, bx1_r, by1_r;

  // stage 2: products and collinear flags
  logic signed [DW-1:0] s1x, s1y, s2x, s2y, dx, dy;
  logic signed [PW-1:0] p_den_a_r, p_den_b_r, p_na_a_r, p_na_b_r, p_nb_a_r, p_nb_b_r;
  logic hit_x_nxt, hit_y_nxt, s1y_zero_nxt;
  logic hit_x_r, hit_y_r, s1y_zero_r;

  // stage 3: cross products
  logic signed [CW-1:0] den_nxt, numa_nxt, numb_nxt;
  logic signed [CW-1:0] den_r, numa_r, numb_r;
  logic hit_x3_r, hit_y3_r, s1y_zero3_r;

  // stage 4: verdict
  logic den_zero, win_a, win_b, hit;
  segint_pkg::verdict_t verdict_nxt, out_verdict_r;

  assign en        = !out_valid_r || out_ready;
  assign in_ready  = en;
  assign out_valid = out_valid_r;
  assign out_verdict = out_verdict_r;

  function automatic logic between(input logic signed [COORD_WIDTH-1:0] a,
                                   input logic signed [COORD_WIDTH-1:0] b,
                                   input logic signed [COORD_WIDTH-1:0] v);
    between = ((a <= v) && (v <= b)) || ((b <= v) && (v <= a));
  endfunction

  function automatic logic in_win(input logic signed [CW-1:0] num,
                                  input logic signed [CW-1:0] den);
    logic signed [CW-1:0] zero;
    zero = '0;
    if (den < zero) in_win = (den <= num) && (num <= zero);
    else            in_win = (zero <= num) && (num <= den);
  endfunction

  always_comb begin
    s1x = DW'(ax1_r) - DW'(ax0_r);
    s1y = DW'(ay1_r) - DW'(ay0_r);
    s2x = DW'(bx1_r) - DW'(bx0_r);
    s2y = DW'(by1_r) - DW'(by0_r);
    dx  = DW'(ax0_r) - DW'(bx0_r);
    dy  = DW'(ay0_r) - DW'(by0_r);
    hit_x_nxt = between(ax0_r, ax1_r, bx0_r) || between(ax0_r, ax1_r, bx1_r) ||
                between(bx0_r, bx1_r, ax0_r) || between(bx0_r, bx1_r, ax1_r);
    hit_y_nxt = between(ay0_r, ay1_r, by0_r) || between(ay0_r, ay1_r, by1_r) ||
                between(by0_r, by1_r, ay0_r) || between(by0_r, by1_r, ay1_r);
    s1y_zero_nxt = (s1y == '0);
  end

  always_comb begin
    den_nxt  = CW'(p_den_a_r) - CW'(p_den_b_r);
    numa_nxt = CW'(p_na_a_r) - CW'(p_na_b_r);
    numb_nxt = CW'(p_nb_a_r) - CW'(p_nb_b_r);
  end

  always_comb begin
    den_zero = (den_r == '0);
    win_a    = in_win(numa_r, den_r);
    win_b    = in_win(numb_r, den_r);
    // collinear pairs: project on x when segment A is horizontal, else on y
    hit      = s1y_zero3_r ? hit_x3_r : hit_y3_r;
    verdict_nxt = segint_pkg::VERDICT_NONE;
    if (!den_zero) begin
      if (win_a && win_b) verdict_nxt = segint_pkg::VERDICT_POINT;
    end else if (numa_r == '0 && numb_r == '0 && hit) begin
      verdict_nxt = segint_pkg::VERDICT_OVERLAP;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      v1_r        <= in_valid;
      v2_r        <= v1_r;
      v3_r        <= v2_r;
      out_valid_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ax0_r <= in_a_start_x;
      ay0_r <= in_a_start_y;
      ax1_r <= in_a_end_x;
      ay1_r <= in_a_end_y;
      bx0_r <= in_b_start_x;
      by0_r <= in_b_start_y;
      bx1_r <= in_b_end_x;
      by1_r <= in_b_end_y;

      p_den_a_r  <= PW'(s1x * s2y);
      p_den_b_r  <= PW'(s1y * s2x);
      p_na_a_r   <= PW'(s1x * dy);
      p_na_b_r   <= PW'(s1y * dx);
      p_nb_a_r   <= PW'(s2x * dy);
      p_nb_b_r   <= PW'(s2y * dx);
      hit_x_r    <= hit_x_nxt;
      hit_y_r    <= hit_y_nxt;
      s1y_zero_r <= s1y_zero_nxt;

      den_r       <= den_nxt;
      numa_r      <= numa_nxt;
      numb_r      <= numb_nxt;
      hit_x3_r    <= hit_x_r;
      hit_y3_r    <= hit_y_r;
      s1y_zero3_r <= s1y_zero_r;

      out_verdict_r <= verdict_nxt;
    end
  end

`ifndef SYNTHESIS
  a_no_code3: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_verdict == segint_pkg::VERDICT_NONE ||
                   out_verdict == segint_pkg::VERDICT_POINT ||
                   out_verdict == segint_pkg::VERDICT_OVERLAP))
    else $error("verdict code out of range");

  a_accept_fills: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> v1_r)
    else $error("accepted beat lost at input register");

  a_ready_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (out_valid && !out_ready))
    else $error("input stalled without output back-pressure");

  a_overlap_parallel: assert property (@(posedge clk) disable iff (!rst_n)
    (v3_r && !den_zero) |-> (verdict_nxt != segint_pkg::VERDICT_OVERLAP))
    else $error("overlap reported for non-parallel segments");

  a_pipe_advance: assert property (@(posedge clk) disable iff (!rst_n)
    (v3_r && en) |=> out_valid)
    else $error("result lost between cross and verdict stages");
`endif

endmodule

/* bench/tb_top.sv */
// Self-checking bench for segment_intersection_test: random and hand-picked segment pairs,
// verdicts predicted in the bench and compared beat by beat against out_verdict.
// Depends on segint_pkg and the segment_intersection_test RTL.
`timescale 1ns / 1ps

module tb_top;

  localparam int COORD_W = 16;

  typedef struct packed {
    logic [COORD_W-1:0] a_start_x;
    logic [COORD_W-1:0] a_start_y;
    logic [COORD_W-1:0] a_end_x;
    logic [COORD_W-1:0] a_end_y;
    logic [COORD_W-1:0] b_start_x;
    logic [COORD_W-1:0] b_start_y;
    logic [COORD_W-1:0] b_end_x;
    logic [COORD_W-1:0] b_end_y;
  } seg_pair_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  seg_pair_t            cur_pair = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  segint_pkg::verdict_t out_verdict;

  seg_pair_t            pair_q[$];
  segint_pkg::verdict_t verdict_q[$];
  int                   n_total = 0;
  int                   n_sent = 0;
  int                   n_err = 0;
  int                   hold_left = 0;
  bit                   held = 1'b0;

  always #5 clk = ~clk;

  segment_intersection_test #(.COORD_WIDTH(COORD_W)) uut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_a_start_x (cur_pair.a_start_x),
    .in_a_start_y (cur_pair.a_start_y),
    .in_a_end_x   (cur_pair.a_end_x),
    .in_a_end_y   (cur_pair.a_end_y),
    .in_b_start_x (cur_pair.b_start_x),
    .in_b_start_y (cur_pair.b_start_y),
    .in_b_end_x   (cur_pair.b_end_x),
    .in_b_end_y   (cur_pair.b_end_y),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_verdict  (out_verdict)
  );

  // ---------------------------------------------------------------- prediction

  // parameter num/den inside [0,1], checked without dividing
  function automatic bit in_unit_range(longint num, longint den);
    if (den < 0)
      return (den <= num) && (num <= 0);
    return (num >= 0) && (num <= den);
  endfunction

  function automatic bit covers(longint e0, longint e1, longint v);
    longint lo;
    longint hi;
    lo = (e0 < e1) ? e0 : e1;
    hi = (e0 < e1) ? e1 : e0;
    return (lo <= v) && (v <= hi);
  endfunction

  function automatic segint_pkg::verdict_t predict_verdict(seg_pair_t p);
    longint ax0, ay0, ax1, ay1, bx0, by0, bx1, by1;
    longint s1x, s1y, s2x, s2y, ox, oy;
    longint den, num_a, num_b;
    bit     hit;
    ax0 = $signed(p.a_start_x);
    ay0 = $signed(p.a_start_y);
    ax1 = $signed(p.a_end_x);
    ay1 = $signed(p.a_end_y);
    bx0 = $signed(p.b_start_x);
    by0 = $signed(p.b_start_y);
    bx1 = $signed(p.b_end_x);
    by1 = $signed(p.b_end_y);
    s1x = ax1 - ax0;
    s1y = ay1 - ay0;
    s2x = bx1 - bx0;
    s2y = by1 - by0;
    ox = ax0 - bx0;
    oy = ay0 - by0;
    den   = s1x * s2y - s1y * s2x;
    num_a = s1x * oy - s1y * ox;
    num_b = s2x * oy - s2y * ox;
    if (den != 0) begin
      if (in_unit_range(num_a, den) && in_unit_range(num_b, den))
        return segint_pkg::VERDICT_POINT;
      return segint_pkg::VERDICT_NONE;
    end
    if (num_a != 0 || num_b != 0)
      return segint_pkg::VERDICT_NONE;
    // collinear: project on x when A has no y extent, else on y
    if (s1y == 0)
      hit = covers(ax0, ax1, bx0) || covers(ax0, ax1, bx1) ||
            covers(bx0, bx1, ax0) || covers(bx0, bx1, ax1);
    else
      hit = covers(ay0, ay1, by0) || covers(ay0, ay1, by1) ||
            covers(by0, by1, ay0) || covers(by0, by1, ay1);
    return hit ? segint_pkg::VERDICT_OVERLAP : segint_pkg::VERDICT_NONE;
  endfunction

  // ---------------------------------------------------------------- stimulus helpers

  function automatic seg_pair_t mk_pair(int ax0, int ay0, int ax1, int ay1,
                                        int bx0, int by0, int bx1, int by1);
    seg_pair_t p;
    p.a_start_x = COORD_W'(ax0);
    p.a_start_y = COORD_W'(ay0);
    p.a_end_x   = COORD_W'(ax1);
    p.a_end_y   = COORD_W'(ay1);
    p.b_start_x = COORD_W'(bx0);
    p.b_start_y = COORD_W'(by0);
    p.b_end_x   = COORD_W'(bx1);
    p.b_end_y   = COORD_W'(by1);
    return p;
  endfunction

  // all four endpoints on the line through (px,py) with direction (dx,dy)
  function automatic seg_pair_t on_line(int px, int py, int dx, int dy,
                                        int t0, int t1, int t2, int t3);
    return mk_pair(px + t0 * dx, py + t0 * dy, px + t1 * dx, py + t1 * dy,
                   px + t2 * dx, py + t2 * dy, px + t3 * dx, py + t3 * dy);
  endfunction

  function automatic int srand(int n);
    return int'($urandom_range(2 * n)) - n;
  endfunction

  function automatic logic [COORD_W-1:0] rand_coord();
    case ($urandom_range(7))
      0: return {1'b1, {(COORD_W-1){1'b0}}};
      1: return {1'b0, {(COORD_W-1){1'b1}}};
      2: return '0;
      3: return '1;
      default: return COORD_W'($urandom);
    endcase
  endfunction

  // thirds of the run: sender idles 10% / 67% / never, receiver the other way round
  function automatic int idle_pct(bit sender);
    if (n_sent < n_total / 3)
      return sender ? 10 : 67;
    if (n_sent < 2 * n_total / 3)
      return sender ? 67 : 10;
    return 0;
  endfunction

  // ---------------------------------------------------------------- driver

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        verdict_q.push_back(predict_verdict(cur_pair));
        n_sent <= n_sent + 1;
      end
      if (!in_valid || in_ready) begin
        if (pair_q.size() > 0 && $urandom_range(99) >= idle_pct(1'b1)) begin
          cur_pair <= pair_q.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------- monitor

  always @(posedge clk) begin : observe
    segint_pkg::verdict_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (verdict_q.size() == 0) begin
          $display("%0t: result beat with nothing expected, actual %0d", $time, out_verdict);
          n_err++;
        end else begin
          want = verdict_q.pop_front();
          if (out_verdict !== want) begin
            $display("%0t: verdict mismatch, expected %0d actual %0d",
                     $time, want, out_verdict);
            n_err++;
          end
        end
      end
      // one long back-pressure stretch so the pipe fills and in_ready drops
      if (!held && n_total > 0 && n_sent >= n_total / 6) begin
        held = 1'b1;
        hold_left = 300;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= idle_pct(1'b0));
      end
    end
  end

  // ---------------------------------------------------------------- sequence

  initial begin
    int        kind, px, py, dx, dy, off;
    seg_pair_t p;

    // hand-picked cases
    pair_q.push_back(mk_pair(0, 0, 10, 10, 0, 10, 10, 0));       // plain crossing
    pair_q.push_back(mk_pair(0, 0, 10, 0, 10, -5, 10, 5));       // touch at A end
    pair_q.push_back(mk_pair(0, 0, 10, 0, 0, -5, 0, 5));         // touch at A start
    pair_q.push_back(mk_pair(0, 0, 10, 0, 11, -5, 11, 5));       // just past A end
    pair_q.push_back(mk_pair(0, 0, 10, 10, 10, 0, 0, 10));       // crossing, positive denominator
    pair_q.push_back(mk_pair(0, 0, 10, 0, 0, 1, 10, 1));         // parallel, apart
    pair_q.push_back(mk_pair(0, 0, 10, 0, 5, 0, 20, 0));         // collinear on x, overlap
    pair_q.push_back(mk_pair(0, 0, 10, 0, 11, 0, 20, 0));        // collinear on x, gap
    pair_q.push_back(mk_pair(0, 0, 10, 0, 10, 0, 20, 0));        // collinear, shared end
    pair_q.push_back(mk_pair(3, 0, 3, 10, 3, -5, 3, 2));         // collinear on y, overlap
    pair_q.push_back(mk_pair(0, 0, 5, 5, 6, 6, 9, 9));           // diagonal, gap
    pair_q.push_back(mk_pair(2, 2, 3, 3, 0, 0, 9, 9));           // A inside B
    pair_q.push_back(mk_pair(4, 4, 4, 4, 0, 0, 9, 9));           // point A on B
    pair_q.push_back(mk_pair(4, 5, 4, 5, 0, 0, 9, 9));           // point A off B's line
    pair_q.push_back(mk_pair(5, 100, 5, 100, 5, 0, 5, 10));      // point A, x-only projection
    pair_q.push_back(mk_pair(7, -3, 7, -3, 7, -3, 7, -3));       // two equal points
    pair_q.push_back(mk_pair(1, 1, 1, 1, 2, 2, 2, 2));           // two distinct points
    pair_q.push_back(mk_pair(0, 0, 10, 0, 5, 0, 5, 0));          // point B on A
    pair_q.push_back(mk_pair(-32768, -32768, -32768, -32768,
                             -32768, -32768, -32768, -32768));
    pair_q.push_back(mk_pair(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767));
    pair_q.push_back(mk_pair(-32768, -32768, 32767, 32767, -32768, 32767, 32767, -32768));
    pair_q.push_back(mk_pair(-32768, -32768, 32767, -32768, -32768, 32767, 32767, 32767));
    pair_q.push_back(mk_pair(-32768, 0, 32767, 0, 32767, 0, -32768, 0));
    pair_q.push_back(mk_pair(21845, -21846, -21846, 21845, 21845, 21845, -21846, -21846));
    pair_q.push_back(mk_pair(0, 0, 10, 10, 20, 0, 12, 8));       // lines meet beyond B

    for (int i = 0; i < 1000; i++) begin
      kind = $urandom_range(9);
      px = srand(10000);
      py = srand(10000);
      dx = srand(40);
      dy = srand(40);
      case ($urandom_range(3))
        0: dy = 0;
        1: dx = 0;
        default: ;
      endcase
      case (kind)
        0, 1: p = {rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                   rand_coord(), rand_coord(), rand_coord(), rand_coord()};
        2, 3: p = mk_pair(srand(20), srand(20), srand(20), srand(20),
                          srand(20), srand(20), srand(20), srand(20));
        4, 5: p = on_line(px, py, dx, dy, srand(200), srand(200), srand(200), srand(200));
        6: begin
          p = mk_pair(srand(50), srand(50), srand(50), srand(50),
                      srand(50), srand(50), srand(50), srand(50));
          if ($urandom_range(1)) begin
            p.b_start_x = p.a_end_x;
            p.b_start_y = p.a_end_y;
          end else begin
            p.b_end_x = p.a_start_x;
            p.b_end_y = p.a_start_y;
          end
        end
        7: begin
          p = on_line(px, py, dx, dy, srand(200), srand(200), srand(200), srand(200));
          if ($urandom_range(1)) begin
            p.a_end_x = p.a_start_x;
            p.a_end_y = p.a_start_y;
          end else begin
            p.b_end_x = p.b_start_x;
            p.b_end_y = p.b_start_y;
          end
        end
        8: begin
          // parallel copy nudged off the line
          p = on_line(px, py, dx, dy, srand(200), srand(200), srand(200), srand(200));
          off = srand(3);
          if (dy == 0) begin
            p.b_start_y = p.b_start_y + COORD_W'(off);
            p.b_end_y   = p.b_end_y + COORD_W'(off);
          end else begin
            p.b_start_x = p.b_start_x + COORD_W'(off);
            p.b_end_x   = p.b_end_x + COORD_W'(off);
          end
        end
        default: p = mk_pair(srand(1000), srand(1000), srand(1000), srand(1000),
                             srand(1000), srand(1000), srand(1000), srand(1000));
      endcase
      pair_q.push_back(p);
    end
    n_total = pair_q.size();

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    while (n_sent < n_total || verdict_q.size() != 0)
      @(posedge clk);
    // pipeline is four deep; give any stray beat time to show up
    repeat (12) @(posedge clk);
    if (n_err == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    #2000000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

/* segment_intersection_test.f */
sv/segint_pkg.sv
sv/segment_intersection_test.sv
bench/tb_top.sv
